// ===== src/fca_pkg.sv =====
// Package for the EtherCAT frame assembler: shared types, constants and the CRC byte update.
// No dependencies.
package fca_pkg;

    localparam int STORE_DEPTH_DEF = 2048;
    localparam int MIN_FRAME_DEF   = 64;
    localparam int OFS_W           = 12;
    localparam int SUM_W           = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 48;

    localparam logic [OFS_W-1:0] HEAD_BYTES  = 12'd16;
    localparam logic [OFS_W-1:0] DG_HDR_LAST = 12'd9;
    localparam logic [OFS_W-1:0] DG_HDR_LEN  = 12'd10;
    localparam logic [OFS_W-1:0] FCS_BYTES   = 12'd4;
    localparam logic [OFS_W-1:0] CAP_RESET   = 12'd1518;
    localparam logic [31:0]      CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0]      CRC_POLY    = 32'hEDB8_8320;

    typedef enum logic [1:0] {
        ACT_HEADER   = 2'd0,
        ACT_PAYLOAD  = 2'd1,
        ACT_FINALIZE = 2'd2,
        ACT_DRAIN    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_NO_DG    = 2'd2,
        ST_SEQUENCE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SRC_MAC = 2'd0,
        REG_DST_MAC = 2'd1,
        REG_CAP     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  command;
        logic [7:0]  index;
        logic [31:0] address;
        logic [10:0] payload_length;
        logic        more_follows;
        logic        has_payload;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [47:0]      src_mac;
        logic [47:0]      dst_mac;
        logic [OFS_W-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       frame_byte;
        logic             byte_valid;
        logic             last_byte;
        logic [OFS_W-1:0] total_len;
        logic [7:0]       datagram_total;
    } result_t;

    // Reflected CRC-32, one byte (eight bit steps).
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/fca_store.sv =====
// Frame byte store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module fca_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== src/fca_engine.sv =====
// Sequencer for the frame assembler: builds, finalizes and drains the frame in fca_store.
// Depends on fca_pkg and fca_store.
module fca_engine #(
    parameter int STORE_DEPTH = fca_pkg::STORE_DEPTH_DEF,
    parameter int MIN_FRAME   = fca_pkg::MIN_FRAME_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  fca_pkg::item_t   item,
    input  fca_pkg::cfg_t    cfg,
    output logic             idle,
    output logic             res_valid,
    output fca_pkg::result_t res
);
    import fca_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(STORE_DEPTH);
    localparam logic [OFS_W-1:0] PAD_END = OFS_W'(MIN_FRAME - 4);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HDR   = 9'b000000010,
        S_FILL  = 9'b000000100,
        S_WKC   = 9'b000001000,
        S_FHEAD = 9'b000010000,
        S_FPAD  = 9'b000100000,
        S_CRC   = 9'b001000000,
        S_FCS   = 9'b010000000,
        S_DRAIN = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [OFS_W-1:0] wofs_reg, wofs_next;
    logic [7:0]       dg_reg, dg_next;
    logic [10:0]      remain_reg, remain_next;
    logic [OFS_W-1:0] flen_reg, flen_next;
    logic [OFS_W-1:0] rptr_reg, rptr_next;
    logic [31:0]      crc_reg, crc_next;
    logic [OFS_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    item_t            it_reg, it_next;

    logic             mem_we, mem_re;
    logic [OFS_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata, mem_rdata;

    logic             finalized;
    logic [SUM_W-1:0] cap_s, need_s;
    logic [10:0]      dlen;
    logic [1:0]       st;
    logic             done;
    logic [7:0]       fbyte;
    logic             bvalid, blast;

    fca_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr[AW-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign finalized = (flen_reg != '0);
    assign cap_s     = ({1'b0, cfg.capacity} < DEPTH_S) ? {1'b0, cfg.capacity} : DEPTH_S;
    assign need_s    = {1'b0, wofs_reg} + SUM_W'(16) + {2'b0, item.payload_length};
    assign dlen      = 11'(wofs_reg - HEAD_BYTES);
    assign idle      = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        wofs_next   = wofs_reg;
        dg_next     = dg_reg;
        remain_next = remain_reg;
        flen_next   = flen_reg;
        rptr_next   = rptr_reg;
        crc_next    = crc_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        it_next     = it_reg;
        mem_we      = 1'b0;
        mem_waddr   = wofs_reg;
        mem_wdata   = 8'd0;
        mem_re      = 1'b0;
        mem_raddr   = rptr_reg;
        st          = ST_OK;
        done        = 1'b0;
        fbyte       = 8'd0;
        bvalid      = 1'b0;
        blast       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (item.action)
                        ACT_HEADER: begin
                            if (finalized || remain_reg != '0) begin
                                st = ST_SEQUENCE; done = 1'b1;
                            end else if (need_s > cap_s) begin
                                st = ST_NO_ROOM; done = 1'b1;
                            end else begin
                                it_next    = item;
                                cnt_next   = '0;
                                state_next = S_HDR;
                            end
                        end
                        ACT_PAYLOAD: begin
                            if (finalized || remain_reg == '0) begin
                                st = ST_SEQUENCE; done = 1'b1;
                            end else begin
                                mem_we      = 1'b1;
                                mem_wdata   = item.data_byte;
                                wofs_next   = wofs_reg + 1'b1;
                                remain_next = remain_reg - 1'b1;
                                if (remain_reg == 11'd1) begin
                                    cnt_next   = '0;
                                    state_next = S_WKC;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                        end
                        ACT_FINALIZE: begin
                            if (finalized || remain_reg != '0) begin
                                st = ST_SEQUENCE; done = 1'b1;
                            end else if (dg_reg == '0) begin
                                st = ST_NO_DG; done = 1'b1;
                            end else begin
                                cnt_next   = '0;
                                state_next = S_FHEAD;
                            end
                        end
                        default: begin
                            if (!finalized || remain_reg != '0) begin
                                st = ST_SEQUENCE; done = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = rptr_reg;
                                state_next = S_DRAIN;
                            end
                        end
                    endcase
                end
            end
            S_HDR: begin
                mem_we    = 1'b1;
                mem_waddr = wofs_reg + cnt_reg;
                case (cnt_reg[3:0])
                    4'd0:    mem_wdata = it_reg.command;
                    4'd1:    mem_wdata = it_reg.index;
                    4'd2:    mem_wdata = it_reg.address[7:0];
                    4'd3:    mem_wdata = it_reg.address[15:8];
                    4'd4:    mem_wdata = it_reg.address[23:16];
                    4'd5:    mem_wdata = it_reg.address[31:24];
                    4'd6:    mem_wdata = it_reg.payload_length[7:0];
                    4'd7:    mem_wdata = {it_reg.more_follows, 4'd0,
                                          it_reg.payload_length[10:8]};
                    default: mem_wdata = 8'd0;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DG_HDR_LAST) begin
                    wofs_next = wofs_reg + DG_HDR_LEN;
                    dg_next   = dg_reg + 1'b1;
                    cnt_next  = '0;
                    if (it_reg.has_payload && it_reg.payload_length != '0) begin
                        remain_next = it_reg.payload_length;
                        state_next  = S_IDLE;
                        done        = 1'b1;
                    end else if (it_reg.payload_length == '0) begin
                        state_next = S_WKC;
                    end else begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = wofs_reg + cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == {1'b0, it_reg.payload_length - 1'b1}) begin
                    wofs_next  = wofs_reg + {1'b0, it_reg.payload_length};
                    cnt_next   = '0;
                    state_next = S_WKC;
                end
            end
            S_WKC: begin
                mem_we    = 1'b1;
                mem_waddr = wofs_reg + cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[0]) begin
                    wofs_next  = wofs_reg + 12'd2;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                    done       = 1'b1;
                end
            end
            S_FHEAD: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                case (cnt_reg[3:0])
                    4'd0:  mem_wdata = cfg.dst_mac[47:40];
                    4'd1:  mem_wdata = cfg.dst_mac[39:32];
                    4'd2:  mem_wdata = cfg.dst_mac[31:24];
                    4'd3:  mem_wdata = cfg.dst_mac[23:16];
                    4'd4:  mem_wdata = cfg.dst_mac[15:8];
                    4'd5:  mem_wdata = cfg.dst_mac[7:0];
                    4'd6:  mem_wdata = cfg.src_mac[47:40];
                    4'd7:  mem_wdata = cfg.src_mac[39:32];
                    4'd8:  mem_wdata = cfg.src_mac[31:24];
                    4'd9:  mem_wdata = cfg.src_mac[23:16];
                    4'd10: mem_wdata = cfg.src_mac[15:8];
                    4'd11: mem_wdata = cfg.src_mac[7:0];
                    4'd12: mem_wdata = 8'h88;
                    4'd13: mem_wdata = 8'hA4;
                    4'd14: mem_wdata = dlen[7:0];
                    default: mem_wdata = {5'b00010, dlen[10:8]};
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == HEAD_BYTES - 1'b1) begin
                    cnt_next   = '0;
                    crc_next   = CRC_INIT;
                    state_next = (wofs_reg < PAD_END) ? S_FPAD : S_CRC;
                end
            end
            S_FPAD: begin
                mem_we    = 1'b1;
                mem_waddr = wofs_reg;
                wofs_next = wofs_reg + 1'b1;
                if (wofs_next >= PAD_END) begin
                    state_next = S_CRC;
                end
            end
            S_CRC: begin
                if (pend_reg) begin
                    crc_next = crc_byte(crc_reg, mem_rdata);
                end
                if (cnt_reg < wofs_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    cnt_next   = '0;
                    state_next = S_FCS;
                end
            end
            S_FCS: begin
                mem_we    = 1'b1;
                mem_waddr = wofs_reg + cnt_reg;
                case (cnt_reg[1:0])
                    2'd0:    mem_wdata = ~crc_reg[7:0];
                    2'd1:    mem_wdata = ~crc_reg[15:8];
                    2'd2:    mem_wdata = ~crc_reg[23:16];
                    default: mem_wdata = ~crc_reg[31:24];
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3) begin
                    flen_next  = wofs_reg + FCS_BYTES;
                    rptr_next  = '0;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                    done       = 1'b1;
                end
            end
            S_DRAIN: begin
                fbyte  = mem_rdata;
                bvalid = 1'b1;
                done   = 1'b1;
                state_next = S_IDLE;
                if (rptr_reg + 1'b1 >= flen_reg) begin
                    blast       = 1'b1;
                    wofs_next   = HEAD_BYTES;
                    dg_next     = '0;
                    remain_next = '0;
                    flen_next   = '0;
                    rptr_next   = '0;
                    crc_next    = CRC_INIT;
                end else begin
                    rptr_next = rptr_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            wofs_reg   <= HEAD_BYTES;
            dg_reg     <= '0;
            remain_reg <= '0;
            flen_reg   <= '0;
            rptr_reg   <= '0;
            crc_reg    <= CRC_INIT;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wofs_reg   <= wofs_next;
            dg_reg     <= dg_next;
            remain_reg <= remain_next;
            flen_reg   <= flen_next;
            rptr_reg   <= rptr_next;
            crc_reg    <= crc_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        it_reg <= it_next;
    end

    assign res_valid          = done;
    assign res.status         = st;
    assign res.frame_byte     = fbyte;
    assign res.byte_valid     = bvalid;
    assign res.last_byte      = blast;
    assign res.total_len      = flen_next;
    assign res.datagram_total = dg_next;

endmodule

// ===== src/ethercat_frame_assembler_top.sv =====
// Top level of the EtherCAT frame assembler: configuration registers, input handshake and
// result register. Depends on fca_pkg and fca_engine.
//
// Builds one EtherCAT frame (Ethernet header, type-1 EtherCAT header, datagrams, padding
// and CRC-32 FCS) in a byte RAM of STORE_DEPTH entries and reads it back out one byte per
// drain transfer. Every input transfer yields exactly one result transfer. A payload byte,
// a refused item or an out-of-sequence item is answered straight from the accept cycle; a
// payload byte that completes its datagram first writes the two working-counter bytes; a
// datagram header writes its ten header bytes, then payload_length bytes of zero fill when
// no payload transfers follow, then the working counter unless payload transfers follow; a
// drain waits for the registered RAM read data; finalize rewrites the header, pads to
// MIN_FRAME-4 bytes, runs the CRC pass over the frame and writes the FCS, all byte by byte
// through the RAM's one write port and one read port. A new input transfer is taken when
// the sequencer is idle and the result register is empty or being read. The frame RAM is
// not cleared after reset; bytes 0..15 are written at finalize with the MAC values current
// at that time.
// Configuration writes are always accepted and must only be issued while the block is idle.
module ethercat_frame_assembler_top #(
    parameter int STORE_DEPTH = fca_pkg::STORE_DEPTH_DEF,
    parameter int MIN_FRAME   = fca_pkg::MIN_FRAME_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fca_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic [7:0]                       s_command,
    input  logic [7:0]                       s_index,
    input  logic [31:0]                      s_address,
    input  logic [10:0]                      s_payload_length,
    input  logic                             s_more_follows,
    input  logic                             s_has_payload,
    input  logic [7:0]                       s_data_byte,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [7:0]                       m_frame_byte,
    output logic                             m_byte_valid,
    output logic                             m_last_byte,
    output logic [fca_pkg::OFS_W-1:0]        m_total_len,
    output logic [7:0]                       m_datagram_total
);
    import fca_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    logic    eng_idle, res_valid, in_fire;
    result_t res, res_reg;
    logic    m_valid_reg;

    // Register file: writes take effect at once, no back-pressure.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_mac  <= '0;
            cfg_reg.dst_mac  <= '0;
            cfg_reg.capacity <= CAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_MAC: cfg_reg.src_mac  <= cfg_data;
                REG_DST_MAC: cfg_reg.dst_mac  <= cfg_data;
                REG_CAP:     cfg_reg.capacity <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign item.action         = s_action;
    assign item.command        = s_command;
    assign item.index          = s_index;
    assign item.address        = s_address;
    assign item.payload_length = s_payload_length;
    assign item.more_follows   = s_more_follows;
    assign item.has_payload    = s_has_payload;
    assign item.data_byte      = s_data_byte;

    // One item in flight; the result slot must be free (or draining) at accept.
    assign s_ready = eng_idle && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    fca_engine #(.STORE_DEPTH(STORE_DEPTH), .MIN_FRAME(MIN_FRAME)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .item      (item),
        .cfg       (cfg_reg),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = res_reg.status;
    assign m_frame_byte     = res_reg.frame_byte;
    assign m_byte_valid     = res_reg.byte_valid;
    assign m_last_byte      = res_reg.last_byte;
    assign m_total_len      = res_reg.total_len;
    assign m_datagram_total = res_reg.datagram_total;

endmodule

// ===== src/fca_checker.sv =====
// Port-level checks for the frame assembler, bound to the top level.
// Depends on fca_pkg and ethercat_frame_assembler_top.
module fca_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [7:0]  m_frame_byte,
    input logic        m_byte_valid,
    input logic        m_last_byte,
    input logic [7:0]  m_datagram_total
);
    import fca_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_status))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_byte_valid && m_datagram_total == 8'd0)
        else $error("last byte without drained byte or frame restart");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_status == ST_OK)
        else $error("drained byte with error status");

    a_no_dg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NO_DG |-> m_datagram_total == 8'd0 && !m_byte_valid)
        else $error("no-datagram status with datagrams present");

endmodule

bind ethercat_frame_assembler_top fca_checker u_fca_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_frame_byte     (m_frame_byte),
    .m_byte_valid     (m_byte_valid),
    .m_last_byte      (m_last_byte),
    .m_datagram_total (m_datagram_total)
);

// ===== verif/ethercat_frame_assembler_top_test.sv =====
// Self-checking testbench for ethercat_frame_assembler_top: frame building, padding, CRC-32 FCS
// and drain, with random handshake gaps. Depends on fca_pkg and the assembler RTL.
`timescale 1ns / 100ps

module ethercat_frame_assembler_top_test;
    import fca_pkg::*;

    localparam int DEPTH    = 2048;
    localparam int MIN_FRM  = 64;
    localparam int N_ITEMS  = 1000;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  frame_byte;
        logic        byte_valid;
        logic        last_byte;
        logic [11:0] total_len;
        logic [7:0]  datagram_total;
    } frame_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [7:0]  s_command = '0;
    logic [7:0]  s_index = '0;
    logic [31:0] s_address = '0;
    logic [10:0] s_payload_length = '0;
    logic        s_more_follows = 1'b0;
    logic        s_has_payload = 1'b0;
    logic [7:0]  s_data_byte = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_frame_byte;
    logic        m_byte_valid;
    logic        m_last_byte;
    logic [11:0] m_total_len;
    logic [7:0]  m_datagram_total;

    ethercat_frame_assembler_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_command(s_command),
        .s_index(s_index), .s_address(s_address), .s_payload_length(s_payload_length),
        .s_more_follows(s_more_follows), .s_has_payload(s_has_payload),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_frame_byte(m_frame_byte), .m_byte_valid(m_byte_valid), .m_last_byte(m_last_byte),
        .m_total_len(m_total_len), .m_datagram_total(m_datagram_total)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame model: own copy of the store, the build state and the registers
    // ------------------------------------------------------------------
    logic [7:0]  frame_mem [0:DEPTH-1];
    int unsigned wr_ofs, dg_count, pay_left, done_len, rd_ofs;
    logic [47:0] src_mac_q, dst_mac_q;
    int unsigned cap_q;

    item_t         item_q [$];   // items waiting to be offered
    frame_result_t result_q [$]; // predicted results, oldest first

    int unsigned errors, n_sent, n_checked, n_frames, n_refused;
    bit src_burst, sink_burst;   // phases with no idling on that side
    int sink_hold;               // long receiver hold-off, counted below

    task automatic mem_put(int unsigned pos, logic [7:0] v);
        if (pos < DEPTH) frame_mem[pos] = v;
    endtask

    task automatic load_eth_header();
        for (int i = 0; i < 6; i++) begin
            mem_put(i, dst_mac_q[47-8*i -: 8]);
            mem_put(6 + i, src_mac_q[47-8*i -: 8]);
        end
        mem_put(12, 8'h88);
        mem_put(13, 8'hA4);
    endtask

    task automatic new_frame();
        load_eth_header();
        mem_put(14, 8'h00);
        mem_put(15, 8'h10);
        wr_ofs = 16; dg_count = 0; pay_left = 0; done_len = 0; rd_ofs = 0;
    endtask

    task automatic put_wkc();
        mem_put(wr_ofs, 8'h00);
        mem_put(wr_ofs + 1, 8'h00);
        wr_ofs += 2;
    endtask

    // Apply one accepted item and queue the result it must produce
    task automatic assemble_step(input item_t it);
        frame_result_t r;
        bit closed;
        int unsigned cap, len, o;
        logic [15:0] lw;
        logic [31:0] crc;
        closed = (done_len != 0);
        r = '{default: '0};
        r.status = ST_OK;
        case (action_t'(it.action))
            ACT_HEADER: begin
                len = it.payload_length;
                cap = (cap_q < DEPTH) ? cap_q : DEPTH;
                lw = {it.more_follows, 4'd0, it.payload_length};
                if (closed || pay_left != 0) r.status = ST_SEQUENCE;
                else if (wr_ofs + 12 + len + 4 > cap) r.status = ST_NO_ROOM;
                else begin
                    o = wr_ofs;
                    mem_put(o, it.command);
                    mem_put(o + 1, it.index);
                    for (int i = 0; i < 4; i++) mem_put(o + 2 + i, it.address[8*i +: 8]);
                    mem_put(o + 6, lw[7:0]);
                    mem_put(o + 7, lw[15:8]);
                    mem_put(o + 8, 8'h00);
                    mem_put(o + 9, 8'h00);
                    wr_ofs = o + 10;
                    dg_count = (dg_count + 1) & 8'hFF;
                    if (it.has_payload && len > 0) pay_left = len;
                    else begin
                        for (int i = 0; i < len; i++) mem_put(wr_ofs + i, 8'h00);
                        wr_ofs += len;
                        put_wkc();
                    end
                end
            end
            ACT_PAYLOAD: begin
                if (closed || pay_left == 0) r.status = ST_SEQUENCE;
                else begin
                    mem_put(wr_ofs, it.data_byte);
                    wr_ofs++;
                    pay_left--;
                    if (pay_left == 0) put_wkc();
                end
            end
            ACT_FINALIZE: begin
                if (closed || pay_left != 0) r.status = ST_SEQUENCE;
                else if (dg_count == 0) r.status = ST_NO_DG;
                else begin
                    lw = 16'h1000 | ((wr_ofs - 16) & 16'h7FF);
                    load_eth_header();
                    mem_put(14, lw[7:0]);
                    mem_put(15, lw[15:8]);
                    while (wr_ofs < MIN_FRM - 4) begin
                        mem_put(wr_ofs, 8'h00);
                        wr_ofs++;
                    end
                    // reflected CRC-32 over the whole frame, FCS low byte first
                    crc = 32'hFFFF_FFFF;
                    for (int i = 0; i < wr_ofs && i < DEPTH; i++) begin
                        crc ^= {24'd0, frame_mem[i]};
                        for (int k = 0; k < 8; k++)
                            crc = crc[0] ? ((crc >> 1) ^ 32'hEDB8_8320) : (crc >> 1);
                    end
                    crc = ~crc;
                    for (int i = 0; i < 4; i++) mem_put(wr_ofs + i, crc[8*i +: 8]);
                    done_len = wr_ofs + 4;
                    rd_ofs = 0;
                end
            end
            default: begin
                if (!closed || pay_left != 0) r.status = ST_SEQUENCE;
                else begin
                    r.frame_byte = (rd_ofs < DEPTH) ? frame_mem[rd_ofs] : 8'h00;
                    r.byte_valid = 1'b1;
                    if (rd_ofs + 1 >= done_len) begin
                        r.last_byte = 1'b1;
                        n_frames++;
                        new_frame();
                    end else rd_ofs++;
                end
            end
        endcase
        if (r.status != ST_OK) n_refused++;
        r.total_len = done_len[11:0];
        r.datagram_total = dg_count[7:0];
        result_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued items at the falling edge
    // ------------------------------------------------------------------
    logic s_took = 1'b0, m_took = 1'b0;
    int   s_gap = 0, m_wait = 0;

    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
        m_took <= m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            assemble_step('{action: s_action, command: s_command, index: s_index,
                            address: s_address, payload_length: s_payload_length,
                            more_follows: s_more_follows, has_payload: s_has_payload,
                            data_byte: s_data_byte});
            n_sent++;
        end
    end

    always @(negedge aclk) begin
        item_t it;
        if (!aresetn) s_valid <= 1'b0;
        else if (!s_valid || s_took) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                it = item_q.pop_front();
                s_action <= it.action;
                s_command <= it.command;
                s_index <= it.index;
                s_address <= it.address;
                s_payload_length <= it.payload_length;
                s_more_follows <= it.more_follows;
                s_has_payload <= it.has_payload;
                s_data_byte <= it.data_byte;
                s_valid <= 1'b1;
                s_gap <= src_burst ? 0 : $urandom_range(0, 6);
            end else s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, plus the long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (sink_hold > 0) sink_hold <= sink_hold - 1;
    end

    always @(negedge aclk) begin
        int d;
        d = m_took ? (sink_burst ? 0 : $urandom_range(0, 6)) : m_wait;
        if (!aresetn || sink_hold > 0) begin
            m_wait <= d;
            m_ready <= 1'b0;
        end else if (d > 0) begin
            m_wait <= d - 1;
            m_ready <= 1'b0;
        end else begin
            m_wait <= 0;
            m_ready <= 1'b1;
        end
    end

    task automatic mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        frame_result_t e;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (result_q.size() == 0) mismatch("result transfer with nothing predicted");
            else begin
                e = result_q.pop_front();
                if (m_status !== e.status)
                    mismatch($sformatf("status %0d, predicted %0d", m_status, e.status));
                if (m_frame_byte !== e.frame_byte)
                    mismatch($sformatf("frame_byte %02h, predicted %02h",
                                       m_frame_byte, e.frame_byte));
                if (m_byte_valid !== e.byte_valid)
                    mismatch($sformatf("byte_valid %b, predicted %b",
                                       m_byte_valid, e.byte_valid));
                if (m_last_byte !== e.last_byte)
                    mismatch($sformatf("last_byte %b, predicted %b",
                                       m_last_byte, e.last_byte));
                if (m_total_len !== e.total_len)
                    mismatch($sformatf("total_len %0d, predicted %0d",
                                       m_total_len, e.total_len));
                if (m_datagram_total !== e.datagram_total)
                    mismatch($sformatf("datagram_total %0d, predicted %0d",
                                       m_datagram_total, e.datagram_total));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_hdr(logic [7:0] cmd, logic [7:0] idx, logic [31:0] addr,
                            logic [10:0] len, logic more, logic hasp);
        item_t it;
        it = '{action: ACT_HEADER, command: cmd, index: idx, address: addr,
               payload_length: len, more_follows: more, has_payload: hasp,
               data_byte: 8'($urandom)};
        item_q.push_back(it);
    endtask

    task automatic push_op(action_t a, logic [7:0] b);
        item_t it;
        it = '{action: a, command: 8'($urandom), index: 8'($urandom), address: $urandom,
               payload_length: 11'($urandom), more_follows: 1'($urandom),
               has_payload: 1'($urandom), data_byte: b};
        item_q.push_back(it);
    endtask

    task automatic push_rand_hdr(logic [10:0] len, logic hasp);
        push_hdr(8'($urandom), 8'($urandom), $urandom, len, 1'($urandom), hasp);
    endtask

    // refused-without-effect noise that fits the current sequence point
    task automatic noise_open();
        case ($urandom_range(0, 2))
            0: push_op(ACT_DRAIN, 8'($urandom));
            1: push_op(ACT_PAYLOAD, 8'($urandom));
            default: push_rand_hdr(11'h7FF, 1'($urandom)); // never fits
        endcase
    endtask

    task automatic noise_busy();
        case ($urandom_range(0, 2))
            0: push_op(ACT_DRAIN, 8'($urandom));
            1: push_op(ACT_FINALIZE, 8'($urandom));
            default: push_rand_hdr(11'($urandom), 1'($urandom));
        endcase
    endtask

    task automatic noise_closed();
        case ($urandom_range(0, 2))
            0: push_op(ACT_PAYLOAD, 8'($urandom));
            1: push_op(ACT_FINALIZE, 8'($urandom));
            default: push_rand_hdr(11'($urandom_range(0, 8)), 1'($urandom));
        endcase
    endtask

    // one well-formed frame with random content, finalized and drained in full
    task automatic queue_frame(int unsigned cap, bit big);
        int unsigned ofs, len, room, flen, n_dg;
        bit hasp;
        ofs = 16;
        if (cap > DEPTH) cap = DEPTH;
        n_dg = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) push_op(ACT_FINALIZE, 8'($urandom)); // no datagrams
        for (int d = 0; d < n_dg; d++) begin
            if (ofs + 16 > cap) break;
            room = cap - ofs - 16;
            if (big && d == 0) len = room;
            else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 48);
            else len = $urandom_range(0, 10);
            if (len > room) len = room;
            hasp = big ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) noise_open();
            push_rand_hdr(11'(len), hasp);
            if (hasp) begin
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 39) == 0) noise_busy();
                    push_op(ACT_PAYLOAD, 8'($urandom));
                end
            end
            ofs += 12 + len;
        end
        push_op(ACT_FINALIZE, 8'($urandom));
        flen = ((ofs < MIN_FRM - 4) ? MIN_FRM - 4 : ofs) + 4;
        for (int i = 0; i < flen; i++) begin
            if ($urandom_range(0, 49) == 0) noise_closed();
            push_op(ACT_DRAIN, 8'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (!(item_q.size() == 0 && !s_valid && result_q.size() == 0)) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [47:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SRC_MAC: src_mac_q = v;
            REG_DST_MAC: dst_mac_q = v;
            default:     cap_q = v[11:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned cap;
        src_mac_q = '0; dst_mac_q = '0; cap_q = 1518;
        errors = 0; n_sent = 0; n_checked = 0; n_frames = 0; n_refused = 0;
        src_burst = 0; sink_burst = 0; sink_hold = 0;
        new_frame();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset registers, every refusal and every operation
        push_op(ACT_FINALIZE, 8'h00);                        // no datagrams yet
        push_op(ACT_DRAIN, 8'h00);                           // drain before finalize
        push_op(ACT_PAYLOAD, 8'hFF);                         // stray payload byte
        push_hdr(8'h00, 8'hFF, 32'h0, 11'h7FF, 1'b0, 1'b0);  // no room
        push_hdr(8'hFF, 8'h00, 32'hFFFF_FFFF, 11'd3, 1'b1, 1'b1);
        push_op(ACT_FINALIZE, 8'h00);                        // payload still awaited
        push_op(ACT_DRAIN, 8'h00);
        push_op(ACT_PAYLOAD, 8'hFF);
        push_op(ACT_PAYLOAD, 8'h00);
        push_op(ACT_PAYLOAD, 8'hA5);
        push_hdr(8'h5A, 8'hA5, 32'h1234_5678, 11'd0, 1'b0, 1'b1); // empty, flagged
        push_hdr(8'h01, 8'h02, 32'h8000_0001, 11'd5, 1'b1, 1'b0); // zero fill
        push_op(ACT_FINALIZE, 8'h00);
        push_hdr(8'h01, 8'h01, 32'h0, 11'd1, 1'b0, 1'b0);    // after finalize
        push_op(ACT_PAYLOAD, 8'h11);
        push_op(ACT_FINALIZE, 8'h00);
        for (int i = 0; i < MIN_FRM; i++) push_op(ACT_DRAIN, 8'h00);
        wait_idle();

        // Random phases over register settings, extremes first
        for (int ph = 0; n_sent < N_ITEMS || ph < 6; ph++) begin
            case (ph % 6)
                0: begin cfg_write(REG_SRC_MAC, 48'hFFFF_FFFF_FFFF);
                         cfg_write(REG_DST_MAC, 48'h0); cap = 64; end
                1: begin cfg_write(REG_SRC_MAC, 48'h0);
                         cfg_write(REG_DST_MAC, 48'hFFFF_FFFF_FFFF); cap = 2048; end
                2: cap = 1518;
                default: cap = $urandom_range(64, 2048);
            endcase
            if (ph >= 2) begin
                cfg_write(REG_SRC_MAC, {$urandom, 16'($urandom)});
                cfg_write(REG_DST_MAC, {$urandom, 16'($urandom)});
            end
            cfg_write(REG_CAP, 48'(cap));
            src_burst = (ph % 4 == 3);
            sink_burst = (ph % 5 == 4);
            if (ph == 2) sink_hold = 400; // receiver stalls while items keep coming
            for (int f = 0; f < 2; f++) queue_frame(cap, ph == 0 && f == 0);
            wait_idle(); // sender holds until every result is back
        end

        repeat (20) @(posedge aclk);
        $display("Covered %0d transfers in, %0d results checked, %0d frames drained,",
                 n_sent, n_checked, n_frames);
        $display("%0d refused items, capacities 64..2048 with MAC extremes.", n_refused);
        if (errors == 0 && result_q.size() == 0) begin
            $display("ethercat_frame_assembler_top regression: pass");
        end else begin
            $display("%0d mismatches, %0d predictions left", errors, result_q.size());
            $display("ethercat_frame_assembler_top regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d items queued", item_q.size());
        $display("ethercat_frame_assembler_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fca_pkg.sv
src/fca_store.sv
src/fca_engine.sv
src/ethercat_frame_assembler_top.sv
src/fca_checker.sv
verif/ethercat_frame_assembler_top_test.sv
